// ===== design/trajectory_tracking_controller_assert.svh =====
// Assertion macros for the trajectory tracking controller.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef TRAJECTORY_TRACKING_CONTROLLER_ASSERT_SVH
`define TRAJECTORY_TRACKING_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define TTC_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
`define TTC_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define TTC_ASSERT_NOW(label, cond, expr, msg)
`define TTC_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

// ===== design/ttc_pkg.sv =====
// Shared constants, register codes and the exp table generator for the
// trajectory tracking controller. No dependencies.
package ttc_pkg;

    localparam int FIELD_W        = 16;
    localparam int GAIN_W         = 12;
    localparam int LIM_W          = 15;
    localparam int TICK_W         = 16;
    localparam int Q_FRAC         = 8;
    localparam int LAT_SHIFT      = 24;
    localparam int EXP_W          = 9;
    localparam int EXP_TABLE_DEPTH = 64;
    localparam int EXP_SPAN_SHIFT = 11;
    localparam int Q31_SHIFT      = 31;
    localparam int MUL_A_W        = 40;
    localparam int MUL_B_W        = 16;
    localparam int MAG_W          = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    typedef logic signed [FIELD_W-1:0] field_t;
    typedef logic [GAIN_W-1:0]         gain_t;
    typedef logic [LIM_W-1:0]          lim_t;
    typedef logic [TICK_W-1:0]         tick_t;
    typedef longint unsigned           u64_t;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ALONG   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LATERAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_HEADING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LAT_ERR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TRACK    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK_LIMIT  = 3'd7;

    localparam gain_t RST_GAIN        = 12'd256;
    localparam lim_t  RST_MAX_TURN    = 15'd256;
    localparam lim_t  RST_MAX_SPEED   = 15'd256;
    localparam lim_t  RST_MAX_LAT_ERR = 15'd256;
    localparam lim_t  RST_MAX_TRACK   = 15'd128;
    localparam tick_t RST_STUCK_LIMIT = 16'd100;

    // 0.1 m in Q8.8
    localparam field_t GOAL_X_LIMIT = 16'sd26;

    localparam longint unsigned Q31_ONE  = 64'h0000_0000_8000_0000;
    localparam longint unsigned Q31_HALF = 64'h0000_0000_4000_0000;

    // quotient by shift and subtract; only evaluated while the table is built
    function automatic u64_t div_u64(input u64_t num, input u64_t den);
        u64_t quo;
        u64_t rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // round(256*exp(-8x)) with y = x in Q1.31: series of exp(-y), squared three times
    function automatic logic [EXP_W-1:0] exp_entry(input u64_t y);
        u64_t   term;
        u64_t   e;
        longint acc;
        term = Q31_ONE;
        acc  = longint'(Q31_ONE);
        for (int k = 1; k <= 20; k++) begin
            term = div_u64((term * y) >> Q31_SHIFT, u64_t'(k));
            if ((k % 2) == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        e = u64_t'(acc);
        if (e > Q31_ONE)
            e = Q31_ONE;
        for (int s = 0; s < 3; s++)
            e = (e * e) >> Q31_SHIFT;
        e = (e * 64'd256 + Q31_HALF) >> Q31_SHIFT;
        return e[EXP_W-1:0];
    endfunction

endpackage

// ===== design/ttc_serial_mult.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// Uses ttc_pkg for default widths.
`include "trajectory_tracking_controller_assert.svh"

module ttc_serial_mult #(
    parameter int A_W = ttc_pkg::MUL_A_W,
    parameter int B_W = ttc_pkg::MUL_B_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [A_W-1:0]    a,
    input  logic signed [B_W-1:0]    b,
    output logic                     done,
    output logic signed [A_W+B_W-1:0] product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [A_W-1:0]   a_reg;
    logic [B_W-1:0]   b_sr_reg;
    logic [A_W:0]     hi_reg;
    logic [B_W-1:0]   lo_reg;

    logic             last;
    logic [A_W:0]     a_ext;
    logic [A_W:0]     addend;
    logic [A_W+1:0]   sum;
    logic [A_W:0]     hi_next;

    assign last  = (cnt_reg == CNT_W'(B_W - 1));
    assign a_ext = {a_reg[A_W-1], a_reg};

    // top bit of the multiplier carries negative weight
    always_comb
    begin
        if (!b_sr_reg[0])
            addend = '0;
        else if (last)
            addend = -a_ext;
        else
            addend = a_ext;
    end

    assign sum     = {hi_reg[A_W], hi_reg} + {addend[A_W], addend};
    assign hi_next = sum[A_W+1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            b_sr_reg <= b;
            hi_reg   <= '0;
        end
        else if (busy_reg)
        begin
            hi_reg   <= hi_next;
            lo_reg   <= {sum[0], lo_reg[B_W-1:1]};
            b_sr_reg <= {1'b0, b_sr_reg[B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = signed'({hi_reg[A_W-1:0], lo_reg});

    `TTC_ASSERT_NOW(a_start_when_free, start, !busy_reg, "multiplier restarted while busy")
    `TTC_ASSERT_NOW(a_done_not_busy, done_reg, !busy_reg, "done raised while still stepping")
    `TTC_ASSERT_NEXT(a_busy_ends_done, busy_reg, busy_reg || done_reg, "pass ended without done")

endmodule

// ===== design/ttc_exp_rom.sv =====
// Constant table of round(256*exp(-8*i/DEPTH)), registered read.
// Entries are built at elaboration by ttc_pkg::exp_entry.
module ttc_exp_rom #(
    parameter int DEPTH = ttc_pkg::EXP_TABLE_DEPTH,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [IDX_W-1:0]            idx,
    output logic [ttc_pkg::EXP_W-1:0]   data
);

    logic [ttc_pkg::EXP_W-1:0] rom_c [DEPTH];
    logic [ttc_pkg::EXP_W-1:0] data_reg;

    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_entry
        localparam ttc_pkg::u64_t Y = (ttc_pkg::u64_t'(gi) << ttc_pkg::Q31_SHIFT) / DEPTH;
        assign rom_c[gi] = ttc_pkg::exp_entry(Y);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            data_reg <= rom_c[idx];
    end

    assign data = data_reg;

endmodule

// ===== design/trajectory_tracking_controller.sv =====
// An item is taken only while the block is idle; in_stall holds off the next one until
// its result is written. Each item makes nine passes of 16 steps (plus issue and capture) through
// the one bit-serial multiplier that every product of the control law shares.
// The result waits in an output register; a stalled result holds the block in its
// final state. Reset (rst_n, async) clears control state and loads register defaults.
// Top level; uses ttc_pkg, ttc_serial_mult, ttc_exp_rom and the assertion header.
`include "trajectory_tracking_controller_assert.svh"

module trajectory_tracking_controller #(
    parameter int EXP_TABLE_DEPTH = ttc_pkg::EXP_TABLE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ttc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ttc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [ttc_pkg::FIELD_W-1:0] err_x,
    input  logic signed [ttc_pkg::FIELD_W-1:0] err_y,
    input  logic signed [ttc_pkg::FIELD_W-1:0] err_heading,
    input  logic signed [ttc_pkg::FIELD_W-1:0] ref_speed,
    input  logic signed [ttc_pkg::FIELD_W-1:0] ref_turn,
    input  logic                              at_final,
    input  logic                              has_reference,
    input  logic                              new_trajectory,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ttc_pkg::FIELD_W-1:0] speed_cmd,
    output logic signed [ttc_pkg::FIELD_W-1:0] turn_cmd,
    output logic                              end_pulse,
    output logic                              replan,
    output logic [ttc_pkg::TICK_W-1:0]        delay_ticks
);

    localparam int FW      = ttc_pkg::FIELD_W;
    localparam int AW      = ttc_pkg::MUL_A_W;
    localparam int BW      = ttc_pkg::MUL_B_W;
    localparam int PW      = AW + BW;
    localparam int MW      = ttc_pkg::MAG_W;
    localparam int SUM_W   = FW + 6;
    localparam int LATQ_W  = PW - ttc_pkg::LAT_SHIFT;
    localparam int TURN_W  = LATQ_W + 1;
    localparam int T_W     = 2 * FW - 1 - ttc_pkg::Q_FRAC;
    localparam int SCL_W   = T_W + $clog2(EXP_TABLE_DEPTH + 1);
    localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);
    localparam int EW      = ttc_pkg::EXP_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    localparam logic [3:0] OP_EX2  = 4'd0;
    localparam logic [3:0] OP_EY2  = 4'd1;
    localparam logic [3:0] OP_LIM  = 4'd2;
    localparam logic [3:0] OP_SPD  = 4'd3;
    localparam logic [3:0] OP_HDG  = 4'd4;
    localparam logic [3:0] OP_TH2  = 4'd5;
    localparam logic [3:0] OP_LAT1 = 4'd6;
    localparam logic [3:0] OP_LAT2 = 4'd7;
    localparam logic [3:0] OP_LAT3 = 4'd8;

    // configuration
    ttc_pkg::gain_t gain_along_reg, gain_lateral_reg, gain_heading_reg;
    ttc_pkg::lim_t  max_turn_reg, max_speed_reg, max_lat_reg, max_track_reg;
    ttc_pkg::tick_t stuck_limit_reg;

    // control
    logic [1:0]     state_reg, state_next;
    logic [3:0]     op_reg;
    ttc_pkg::tick_t delay_count_reg;
    logic           moving_reg;
    logic           out_valid_reg;

    // item and intermediate values
    ttc_pkg::field_t ex_reg, ey_reg, eth_reg, vref_reg, wref_reg, eys_reg;
    logic            at_final_reg, has_ref_reg, new_traj_reg;
    logic [MW-1:0]   mag_reg, lim2_reg;
    logic signed [SUM_W-1:0]  spd_reg, hdg_reg;
    logic signed [AW-1:0]     lat_reg;
    logic signed [LATQ_W-1:0] latq_reg;
    logic            in_range_reg;

    // result registers
    ttc_pkg::field_t speed_out_reg, turn_out_reg;
    logic            end_out_reg, replan_out_reg;
    ttc_pkg::tick_t  delay_out_reg;

    logic                 in_accept;
    logic                 mul_start, mul_done;
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] product;
    logic signed [PW-1:0] prod_q;
    logic                 th2_done;
    logic [T_W-1:0]       t_val;
    logic [SCL_W-1:0]     idx_wide;
    logic [EW-1:0]        exp_q, exp_val;
    ttc_pkg::field_t      lat_lim, eys_next;
    logic                 can_write, fin_write;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_along_reg   <= ttc_pkg::RST_GAIN;
            gain_lateral_reg <= ttc_pkg::RST_GAIN;
            gain_heading_reg <= ttc_pkg::RST_GAIN;
            max_turn_reg     <= ttc_pkg::RST_MAX_TURN;
            max_speed_reg    <= ttc_pkg::RST_MAX_SPEED;
            max_lat_reg      <= ttc_pkg::RST_MAX_LAT_ERR;
            max_track_reg    <= ttc_pkg::RST_MAX_TRACK;
            stuck_limit_reg  <= ttc_pkg::RST_STUCK_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ttc_pkg::REG_GAIN_ALONG:   gain_along_reg   <= cfg_data[ttc_pkg::GAIN_W-1:0];
                ttc_pkg::REG_GAIN_LATERAL: gain_lateral_reg <= cfg_data[ttc_pkg::GAIN_W-1:0];
                ttc_pkg::REG_GAIN_HEADING: gain_heading_reg <= cfg_data[ttc_pkg::GAIN_W-1:0];
                ttc_pkg::REG_MAX_TURN:     max_turn_reg     <= cfg_data[ttc_pkg::LIM_W-1:0];
                ttc_pkg::REG_MAX_SPEED:    max_speed_reg    <= cfg_data[ttc_pkg::LIM_W-1:0];
                ttc_pkg::REG_MAX_LAT_ERR:  max_lat_reg      <= cfg_data[ttc_pkg::LIM_W-1:0];
                ttc_pkg::REG_MAX_TRACK:    max_track_reg    <= cfg_data[ttc_pkg::LIM_W-1:0];
                ttc_pkg::REG_STUCK_LIMIT:  stuck_limit_reg  <= cfg_data[ttc_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // lateral error saturated on entry
    assign lat_lim = signed'({1'b0, max_lat_reg});
    always_comb
    begin
        if (err_y > lat_lim)
            eys_next = lat_lim;
        else if (err_y < -lat_lim)
            eys_next = -lat_lim;
        else
            eys_next = err_y;
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        case (op_reg)
            OP_EX2:
            begin
                mul_a = {{(AW-FW){ex_reg[FW-1]}}, ex_reg};
                mul_b = ex_reg;
            end
            OP_EY2:
            begin
                mul_a = {{(AW-FW){ey_reg[FW-1]}}, ey_reg};
                mul_b = ey_reg;
            end
            OP_LIM:
            begin
                mul_a = {{(AW-ttc_pkg::LIM_W){1'b0}}, max_track_reg};
                mul_b = {{(BW-ttc_pkg::LIM_W){1'b0}}, max_track_reg};
            end
            OP_SPD:
            begin
                mul_a = {{(AW-ttc_pkg::GAIN_W){1'b0}}, gain_along_reg};
                mul_b = ex_reg;
            end
            OP_HDG:
            begin
                mul_a = {{(AW-ttc_pkg::GAIN_W){1'b0}}, gain_heading_reg};
                mul_b = eth_reg;
            end
            OP_TH2:
            begin
                mul_a = {{(AW-FW){eth_reg[FW-1]}}, eth_reg};
                mul_b = eth_reg;
            end
            OP_LAT1:
            begin
                mul_a = {{(AW-ttc_pkg::GAIN_W){1'b0}}, gain_lateral_reg};
                mul_b = vref_reg;
            end
            OP_LAT2:
            begin
                mul_a = lat_reg;
                mul_b = {{(BW-EW){1'b0}}, exp_val};
            end
            OP_LAT3:
            begin
                mul_a = lat_reg;
                mul_b = eys_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start = (state_reg == S_ISSUE);

    ttc_serial_mult #(
        .A_W(AW),
        .B_W(BW)
    ) u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (product)
    );

    // exp(-eth^2) table index from the squared heading error
    assign th2_done = mul_done && (state_reg == S_WAIT) && (op_reg == OP_TH2);
    assign t_val    = product[2*FW-2:ttc_pkg::Q_FRAC];
    assign idx_wide = ({{(SCL_W-T_W){1'b0}}, t_val} * SCL_W'(EXP_TABLE_DEPTH))
                      >> ttc_pkg::EXP_SPAN_SHIFT;

    ttc_exp_rom #(
        .DEPTH(EXP_TABLE_DEPTH),
        .IDX_W(IDX_W)
    ) u_exp_rom (
        .clk   (clk),
        .rd_en (th2_done),
        .idx   (idx_wide[IDX_W-1:0]),
        .data  (exp_q)
    );

    assign exp_val = in_range_reg ? exp_q : '0;
    assign prod_q  = product >>> ttc_pkg::Q_FRAC;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_accept) state_next = S_ISSUE;
            S_ISSUE: state_next = S_WAIT;
            S_WAIT:
            begin
                if (mul_done)
                    state_next = (op_reg == OP_LAT3) ? S_FIN : S_ISSUE;
            end
            S_FIN:   if (can_write) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // final combine
    ttc_pkg::tick_t           dc0, dc1;
    logic                     big_err, goal;
    logic signed [SUM_W-1:0]  spd_cap;
    logic signed [TURN_W-1:0] turn_sum, turn_lim, turn_neg;
    ttc_pkg::field_t          speed_val, turn_val;
    logic                     end_val, replan_val, moving_next;

    always_comb
    begin
        dc0     = new_traj_reg ? '0 : delay_count_reg;
        big_err = has_ref_reg && (mag_reg > lim2_reg);
        dc1     = (big_err && (dc0 != '1)) ? dc0 + 1'b1 : dc0;
        replan_val = big_err && (dc1 > stuck_limit_reg);
        goal    = at_final_reg && (ex_reg < ttc_pkg::GOAL_X_LIMIT);

        if (spd_reg > signed'(SUM_W'({1'b0, max_speed_reg})))
            spd_cap = signed'(SUM_W'({1'b0, max_speed_reg}));
        else
            spd_cap = spd_reg;

        turn_sum = {{(TURN_W-SUM_W){hdg_reg[SUM_W-1]}}, hdg_reg}
                 + {latq_reg[LATQ_W-1], latq_reg};
        turn_lim = signed'(TURN_W'({1'b0, max_turn_reg}));
        turn_neg = -turn_lim;

        speed_val   = '0;
        turn_val    = '0;
        end_val     = 1'b0;
        moving_next = moving_reg;
        if (has_ref_reg)
        begin
            if (goal)
            begin
                end_val     = moving_reg;
                moving_next = 1'b0;
            end
            else
            begin
                moving_next = 1'b1;
                if (spd_cap < signed'(SUM_W'(-32768)))
                    speed_val = 16'sh8000;
                else
                    speed_val = spd_cap[FW-1:0];
                if (turn_sum > turn_lim)
                    turn_val = turn_lim[FW-1:0];
                else if (turn_sum < turn_neg)
                    turn_val = turn_neg[FW-1:0];
                else
                    turn_val = turn_sum[FW-1:0];
            end
        end
    end

    assign can_write = !out_valid_reg || !out_stall;
    assign fin_write = (state_reg == S_FIN) && can_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_EX2;
            delay_count_reg <= '0;
            moving_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
                op_reg <= OP_EX2;
            else if (state_reg == S_WAIT && mul_done && op_reg != OP_LAT3)
                op_reg <= op_reg + 1'b1;

            if (fin_write)
            begin
                delay_count_reg <= dc1;
                moving_reg      <= moving_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ex_reg       <= err_x;
            ey_reg       <= err_y;
            eth_reg      <= err_heading;
            vref_reg     <= ref_speed;
            wref_reg     <= ref_turn;
            eys_reg      <= eys_next;
            at_final_reg <= at_final;
            has_ref_reg  <= has_reference;
            new_traj_reg <= new_trajectory;
        end

        if (state_reg == S_WAIT && mul_done)
        begin
            case (op_reg)
                OP_EX2:  mag_reg  <= product[MW-1:0];
                OP_EY2:  mag_reg  <= mag_reg + product[MW-1:0];
                OP_LIM:  lim2_reg <= product[MW-1:0];
                OP_SPD:  spd_reg  <= {{(SUM_W-FW){vref_reg[FW-1]}}, vref_reg}
                                     + prod_q[SUM_W-1:0];
                OP_HDG:  hdg_reg  <= {{(SUM_W-FW){wref_reg[FW-1]}}, wref_reg}
                                     + prod_q[SUM_W-1:0];
                OP_TH2:  in_range_reg <= (idx_wide < SCL_W'(EXP_TABLE_DEPTH));
                OP_LAT1: lat_reg  <= product[AW-1:0];
                OP_LAT2: lat_reg  <= product[AW-1:0];
                OP_LAT3: latq_reg <= product[PW-1:ttc_pkg::LAT_SHIFT];
                default: ;
            endcase
        end

        if (fin_write)
        begin
            speed_out_reg  <= speed_val;
            turn_out_reg   <= turn_val;
            end_out_reg    <= end_val;
            replan_out_reg <= replan_val;
            delay_out_reg  <= dc1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign speed_cmd   = speed_out_reg;
    assign turn_cmd    = turn_out_reg;
    assign end_pulse   = end_out_reg;
    assign replan      = replan_out_reg;
    assign delay_ticks = delay_out_reg;

    `TTC_ASSERT_NEXT(a_accept_stalls, in_accept, in_stall, "item taken but input not stalled")
    `TTC_ASSERT_NOW(a_done_in_wait, mul_done, state_reg == S_WAIT, "product landed outside wait")
    `TTC_ASSERT_NOW(a_replan_count, out_valid && replan, delay_ticks != '0, "replan with no delay")
    `TTC_ASSERT_NOW(a_end_stopped, out_valid && end_pulse, speed_cmd == '0 && turn_cmd == '0, "end with motion")

endmodule
